// File: rtl/rctb_pkg.sv
package rctb_pkg;

    // fixed field widths
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned SEC_W  = 16;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned TPS_W  = 8;
    localparam int unsigned TICK_W = SEC_W + TPS_W;

    localparam logic [TPS_W-1:0]  TPS_RESET = 8'd60;
    // largest tick load: 65535 seconds at 255 ticks per second
    localparam logic [TICK_W-1:0] TICKS_MAX = 24'd16711425;

    // command codes
    typedef enum logic [2:0] {
        CMD_CONFIGURE = 3'd0,
        CMD_START     = 3'd1,
        CMD_COMPLETE  = 3'd2,
        CMD_TICK      = 3'd3,
        CMD_READ      = 3'd4
    } t_cmd_code;

    // entry modes
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_DELAY  = 2'd1,
        MODE_REPEAT = 2'd2,
        MODE_DONE   = 2'd3
    } t_mode;

    // command word
    typedef struct packed {
        logic [2:0]       cmd;
        logic [IDX_W-1:0] timer_index;
        logic [SEC_W-1:0] initial_seconds;
        logic [SEC_W-1:0] repeat_seconds;
        logic [CNT_W-1:0] repeat_limit;
        logic [CNT_W-1:0] repeat_start;
    } t_cmd_word;

    // result word
    typedef struct packed {
        logic [1:0]        entry_mode;
        logic [TICK_W-1:0] ticks_left;
        logic [CNT_W-1:0]  repeats_done;
    } t_res_word;

    // one timer entry as kept in the store
    typedef struct packed {
        t_mode             mode;
        logic [SEC_W-1:0]  initial_secs;
        logic [SEC_W-1:0]  period_secs;
        logic [CNT_W-1:0]  limit;
        logic [CNT_W-1:0]  count;
        logic [TICK_W-1:0] ticks;
    } t_entry;

endpackage

// File: rtl/rctb_if.sv
// command channel
interface rctb_cmd_if;
    import rctb_pkg::*;
    logic      valid;
    logic      ready;
    t_cmd_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// result channel
interface rctb_res_if;
    import rctb_pkg::*;
    logic      valid;
    logic      ready;
    t_res_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ticks per second write channel
interface rctb_cfg_if;
    import rctb_pkg::*;
    logic             valid;
    logic             ready;
    logic [TPS_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rctb_advance.sv
module rctb_advance (
    input  rctb_pkg::t_entry                    i_entry,
    input  logic [rctb_pkg::TICK_W-1:0]         i_reload,
    output rctb_pkg::t_entry                    o_entry
);
    import rctb_pkg::*;

    logic             tick_gt1;
    logic             reload_gt1;
    logic [CNT_W-1:0] cnt_inc;
    logic             lim_hit;

    assign tick_gt1   = i_entry.ticks > TICK_W'(1);
    assign reload_gt1 = i_reload > TICK_W'(1);
    assign cnt_inc    = i_entry.count + CNT_W'(1);
    assign lim_hit    = (i_entry.limit != '0) && (cnt_inc >= i_entry.limit);

    // one tick of one entry; delay falls through into a repeat step
    always_comb begin
        o_entry = i_entry;
        case (i_entry.mode)
            MODE_DELAY: begin
                if (tick_gt1) begin
                    o_entry.ticks = i_entry.ticks - TICK_W'(1);
                end else if (reload_gt1) begin
                    // repeat step on the fresh period counts down at once
                    o_entry.ticks = i_reload - TICK_W'(1);
                    o_entry.mode  = MODE_REPEAT;
                end else begin
                    o_entry.count = cnt_inc;
                    o_entry.ticks = i_reload;
                    o_entry.mode  = lim_hit ? MODE_DONE : MODE_REPEAT;
                end
            end
            MODE_REPEAT: begin
                if (tick_gt1) begin
                    o_entry.ticks = i_entry.ticks - TICK_W'(1);
                end else begin
                    o_entry.count = cnt_inc;
                    o_entry.ticks = i_reload;
                    o_entry.mode  = lim_hit ? MODE_DONE : MODE_REPEAT;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/repeating_countdown_timer_bank_top.sv
// channel   dir  modport  word
// i_cmd     in   sink     command, entry index, configure fields
// o_res     out  source   mode, ticks left, repeat count of the entry
// i_cfg     in   sink     ticks per second, always ready
//
// a command other than tick all passes the execute state before the next acceptance
// tick all passes sweep, drain and index read: one store port walks every entry once
// after reset a clearing pass zeroes the store, no command taken
// a result waits in the output register; the next command is accepted meanwhile
// a stalled result holds the following command at its write-back until the slot frees
module repeating_countdown_timer_bank_top #(
    parameter int unsigned TIMER_COUNT = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rctb_cfg_if.sink   i_cfg,
    rctb_cmd_if.sink   i_cmd,
    rctb_res_if.source o_res
);
    import rctb_pkg::*;

    localparam int unsigned AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int unsigned XW = (AW > IDX_W) ? AW : IDX_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SWEEP = 6'b000100,
        S_DRAIN = 6'b001000,
        S_RDIDX = 6'b010000,
        S_EXEC  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [TPS_W-1:0] r_tps;
    t_cmd_word        r_cmd;
    logic [AW-1:0]    r_addr;
    logic             r_idx_ok;
    logic [AW-1:0]    r_sweep_addr, n_sweep_addr;
    logic             r_adv_vld;
    logic [AW-1:0]    r_adv_addr;
    logic             r_out_valid;
    t_res_word        r_out_data;

    t_entry           r_mem [TIMER_COUNT];
    t_entry           r_rdata;

    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;

    logic             cmd_acc;
    logic [XW-1:0]    idx_x;
    logic [AW-1:0]    acc_addr;
    logic             acc_ok;
    logic             sweep_last;
    logic             out_free;
    logic             exec_go;
    logic [SEC_W-1:0] mul_sec;
    logic [TICK_W-1:0] reload;
    t_entry           adv_next;
    t_entry           exec_next;
    logic             exec_wr;
    t_res_word        exec_res;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign idx_x       = XW'(i_cmd.data.timer_index);
    assign acc_addr    = idx_x[AW-1:0];
    assign acc_ok      = 32'(i_cmd.data.timer_index) < 32'(TIMER_COUNT);
    assign sweep_last  = r_sweep_addr == AW'(TIMER_COUNT - 1);
    assign out_free    = !r_out_valid || o_res.ready;
    assign exec_go     = (r_state == S_EXEC) && out_free;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // ticks per second register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_tps <= i_cfg.data;
        end
    end

    // shared reload multiplier: initial seconds for start, period for ticks
    assign mul_sec = (r_state == S_EXEC) ? r_rdata.initial_secs : r_rdata.period_secs;
    assign reload  = {{TPS_W{1'b0}}, mul_sec} * {{SEC_W{1'b0}}, r_tps};

    rctb_advance u_advance (
        .i_entry  (r_rdata),
        .i_reload (reload),
        .o_entry  (adv_next)
    );

    // single-entry command update
    always_comb begin
        exec_next = r_rdata;
        exec_wr   = 1'b0;
        unique case (r_cmd.cmd)
            CMD_CONFIGURE: begin
                exec_next.mode         = MODE_IDLE;
                exec_next.initial_secs = r_cmd.initial_seconds;
                exec_next.period_secs  = r_cmd.repeat_seconds;
                exec_next.limit        = r_cmd.repeat_limit;
                exec_next.count        = r_cmd.repeat_start;
                exec_next.ticks        = '0;
                exec_wr                = 1'b1;
            end
            CMD_START: begin
                exec_next.mode  = MODE_DELAY;
                exec_next.ticks = reload;
                exec_wr         = 1'b1;
            end
            CMD_COMPLETE: begin
                exec_next.mode = MODE_DONE;
                exec_wr        = 1'b1;
            end
            default: ;
        endcase
    end

    // result word, all zero for an index beyond the bank
    always_comb begin
        exec_res = '0;
        if (r_idx_ok) begin
            exec_res.entry_mode   = exec_next.mode;
            exec_res.ticks_left   = exec_next.ticks;
            exec_res.repeats_done = exec_next.count;
        end
    end

    // store port selection
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_addr;
        mem_we    = 1'b0;
        mem_waddr = r_adv_addr;
        mem_wdata = adv_next;
        case (r_state)
            S_IDLE: begin
                mem_re    = cmd_acc;
                mem_raddr = acc_addr;
            end
            S_SWEEP: begin
                mem_re    = 1'b1;
                mem_raddr = r_sweep_addr;
            end
            S_RDIDX: begin
                mem_re = 1'b1;
            end
            default: ;
        endcase
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep_addr;
            mem_wdata = '0;
        end else if (r_adv_vld) begin
            mem_we = 1'b1;
        end else if (exec_go && exec_wr && r_idx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr;
            mem_wdata = exec_next;
        end
    end

    // entry store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        unique case (r_state)
            S_CLEAR: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_sweep_addr = '0;
                if (cmd_acc) begin
                    n_state = (i_cmd.data.cmd == CMD_TICK) ? S_SWEEP : S_EXEC;
                end
            end
            S_SWEEP: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_RDIDX;
            S_RDIDX: n_state = S_EXEC;
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_sweep_addr <= '0;
            r_adv_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_adv_vld    <= (r_state == S_SWEEP);
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_adv_addr <= r_sweep_addr;
        if (cmd_acc) begin
            r_cmd    <= i_cmd.data;
            r_addr   <= acc_addr;
            r_idx_ok <= acc_ok;
        end
        if (exec_go) begin
            r_out_data <= exec_res;
        end
    end

endmodule

// File: rtl/rctb_checker.sv
module rctb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cmd_valid,
    input logic                i_cmd_ready,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input rctb_pkg::t_res_word i_res_word
);
    import rctb_pkg::*;

    // no result shows right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // one command in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command accepted while one is in work");

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_word))
        else $error("stalled result changed");

    // an idle entry has no ticks left
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_word.entry_mode == MODE_IDLE) |-> i_res_word.ticks_left == '0)
        else $error("idle entry with ticks left");

    // ticks never exceed the largest load
    a_ticks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_word.ticks_left <= TICKS_MAX)
        else $error("ticks left beyond the largest load");

endmodule

bind repeating_countdown_timer_bank_top rctb_checker u_rctb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_word  (o_res.data)
);
